### design/shtp_rotation_report_parser_defines.svh
// ----------------------------------------------------------------------------
// shtp_rotation_report_parser_defines
// Assertion macros for the SHTP rotation report parser; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SHTP_ROTATION_REPORT_PARSER_DEFINES_SVH
`define SHTP_ROTATION_REPORT_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SHTP_RPP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shtp_rotation_report_parser: check failed");
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SHTP_RPP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shtp_rotation_report_parser: check failed");
`else
`define SHTP_RPP_ASSERT_IMP(lbl, ante, cons)
`define SHTP_RPP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### design/shtp_rpp_pkg.sv
// ----------------------------------------------------------------------------
// shtp_rpp_pkg
// Types and constants shared by the SHTP rotation report parser modules.
// ----------------------------------------------------------------------------
package shtp_rpp_pkg;

	localparam logic [14:0] MAX_PAYLOAD     = 15'd300;
	localparam logic [14:0] HDR_LEN         = 15'd4;
	localparam logic [14:0] LEN_INVALID     = 15'h7FFF;
	localparam logic [14:0] RESP_MIN        = 15'd6;
	localparam logic [7:0]  CMD_RESPONSE_ID = 8'hF1;
	localparam logic [7:0]  CMD_ME_CAL      = 8'h07;
	localparam logic [3:0]  REPORT_LAST     = 4'd13;
	localparam int          REPORT_BYTES    = 14;
	localparam int          RESP_BYTES      = 6;

	localparam logic [7:0]  RESET_REPORT_ID  = 8'd5;
	localparam logic [7:0]  RESET_INPUT_CH   = 8'd3;
	localparam logic [7:0]  RESET_CONTROL_CH = 8'd2;
	localparam logic [7:0]  RESET_CAL_RESULT = 8'hFF;

	localparam int M_TDATA_W = 120;

	typedef enum logic [1:0] {
		KIND_INVALID  = 2'd0,
		KIND_ROTATION = 2'd1,
		KIND_CAL      = 2'd2,
		KIND_NONE     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CFG_REPORT_ID  = 2'd0,
		CFG_INPUT_CH   = 2'd1,
		CFG_CONTROL_CH = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic       we;
		logic [1:0] index;
		logic [7:0] wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic       packet_start;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		kind_t              result_kind;
		logic [7:0]         packet_channel;
		logic [14:0]        scanned_length;
		logic [1:0]         cal_accuracy;
		logic signed [15:0] quat_i;
		logic signed [15:0] quat_j;
		logic signed [15:0] quat_k;
		logic signed [15:0] quat_real;
		logic signed [15:0] heading_error_raw;
		logic [7:0]         calibration_result;
	} result_t;

endpackage

### design/shtp_rpp_in_stage.sv
// ----------------------------------------------------------------------------
// shtp_rpp_in_stage
// Input register: captures one byte transaction and holds it for the decoder.
// ----------------------------------------------------------------------------
module shtp_rpp_in_stage
	import shtp_rpp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  advance,
	output logic  valid_s1,
	output item_t item_s1
);

	// Take a new byte when the stage is empty or its byte moves on now.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

### design/shtp_rpp_decoder.sv
// ----------------------------------------------------------------------------
// shtp_rpp_decoder
// Packet state, configuration registers and per-byte decode of SHTP packets.
// ----------------------------------------------------------------------------
module shtp_rpp_decoder
	import shtp_rpp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg,
	input  logic    step,
	input  item_t   item,
	output logic    res_valid,
	output result_t res
);

	logic [7:0]  report_id_q, input_ch_q, control_ch_q;
	logic        in_pkt_q;
	logic [14:0] pos_q, len_q;
	logic [7:0]  chan_q;
	logic        mact_q, mfound_q;
	logic [3:0]  moff_q;
	logic [7:0]  rb_q   [REPORT_BYTES];
	logic [7:0]  resp_q [RESP_BYTES];
	logic [1:0]  lacc_q;
	logic [7:0]  lcal_q;

	logic        active, emit;
	logic [7:0]  b;
	logic [14:0] pos, len_c, len_n, p, plen, scanned;
	logic [7:0]  chan_c, chan_n;
	logic        mact_c, mfound_c, mact_n, mfound_n;
	logic [3:0]  moff_c, moff_n, moff_inc;
	logic        rb_we, resp_we;
	logic [3:0]  rb_wa;
	logic [2:0]  resp_wa;
	logic [7:0]  rb_n   [REPORT_BYTES];
	logic [7:0]  resp_n [RESP_BYTES];
	logic [1:0]  lacc_n;
	logic [7:0]  lcal_n;
	logic        in_pkt_n;
	kind_t       kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_id_q  <= RESET_REPORT_ID;
			input_ch_q   <= RESET_INPUT_CH;
			control_ch_q <= RESET_CONTROL_CH;
		end else if (cfg.we) begin
			unique case (cfg_index_t'(cfg.index))
				CFG_REPORT_ID:  report_id_q  <= cfg.wdata;
				CFG_INPUT_CH:   input_ch_q   <= cfg.wdata;
				CFG_CONTROL_CH: control_ch_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		b        = item.data_byte;
		active   = item.packet_start || in_pkt_q;
		pos      = item.packet_start ? '0 : pos_q;
		len_c    = item.packet_start ? '0 : len_q;
		chan_c   = item.packet_start ? '0 : chan_q;
		mact_c   = item.packet_start ? 1'b0 : mact_q;
		mfound_c = item.packet_start ? 1'b0 : mfound_q;
		moff_c   = item.packet_start ? '0 : moff_q;

		len_n    = len_c;
		chan_n   = chan_c;
		mact_n   = mact_c;
		mfound_n = mfound_c;
		moff_n   = moff_c;
		moff_inc = moff_c + 4'd1;
		rb_we    = 1'b0;
		rb_wa    = '0;
		resp_we  = 1'b0;
		in_pkt_n = active;
		emit     = 1'b0;
		kind     = KIND_NONE;
		lacc_n   = lacc_q;
		lcal_n   = lcal_q;
		p        = pos - HDR_LEN;
		plen     = len_c - HDR_LEN;
		scanned  = (plen > MAX_PAYLOAD) ? MAX_PAYLOAD : plen;
		resp_wa  = p[2:0];

		if (pos == 15'd0) begin
			len_n = {7'd0, b};
		end else if (pos == 15'd1) begin
			len_n = len_c | {b[6:0], 8'd0};
		end else if (pos == 15'd2) begin
			chan_n = b;
		end else if (pos == 15'd3) begin
			if (len_c <= HDR_LEN || len_c == LEN_INVALID) begin
				emit     = 1'b1;
				kind     = KIND_INVALID;
				in_pkt_n = 1'b0;
			end
		end else begin
			if (p < MAX_PAYLOAD) begin
				resp_we = (p < RESP_MIN);
				if (mact_c) begin
					moff_n = moff_inc;
					if (moff_inc <= REPORT_LAST) begin
						rb_we = 1'b1;
						rb_wa = moff_inc;
					end
					if (moff_inc >= REPORT_LAST) begin
						mact_n   = 1'b0;
						mfound_n = 1'b1;
					end
				end else if (!mfound_c && b == report_id_q) begin
					rb_we  = 1'b1;
					rb_wa  = '0;
					moff_n = '0;
					mact_n = 1'b1;
				end
			end
			if ((pos + 15'd1) == len_c) begin
				emit     = 1'b1;
				in_pkt_n = 1'b0;
			end
		end

		// Bypass this byte's writes so the last byte of a packet is seen.
		for (int i = 0; i < REPORT_BYTES; i++) begin
			rb_n[i] = (rb_we && rb_wa == 4'(i)) ? b : rb_q[i];
		end
		for (int i = 0; i < RESP_BYTES; i++) begin
			resp_n[i] = (resp_we && resp_wa == 3'(i)) ? b : resp_q[i];
		end

		if (emit && kind != KIND_INVALID) begin
			if (chan_c == input_ch_q) begin
				if (mfound_n) begin
					lacc_n = rb_n[2][1:0];
					kind   = KIND_ROTATION;
				end
			end else if (chan_c == control_ch_q && scanned >= RESP_MIN &&
					resp_n[0] == CMD_RESPONSE_ID && resp_n[2] == CMD_ME_CAL) begin
				lcal_n = resp_n[5];
				kind   = KIND_CAL;
			end
		end
	end

	assign res_valid = step && active && emit;

	always_comb begin
		res = '0;
		res.result_kind        = kind;
		res.packet_channel     = chan_c;
		res.scanned_length     = (kind == KIND_INVALID) ? '0 : scanned;
		res.cal_accuracy       = lacc_n;
		res.calibration_result = lcal_n;
		if (kind == KIND_ROTATION) begin
			res.quat_i            = {rb_n[5], rb_n[4]};
			res.quat_j            = {rb_n[7], rb_n[6]};
			res.quat_k            = {rb_n[9], rb_n[8]};
			res.quat_real         = {rb_n[11], rb_n[10]};
			res.heading_error_raw = {rb_n[13], rb_n[12]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pkt_q <= 1'b0;
			pos_q    <= '0;
			len_q    <= '0;
			chan_q   <= '0;
			mact_q   <= 1'b0;
			mfound_q <= 1'b0;
			moff_q   <= '0;
			lacc_q   <= '0;
			lcal_q   <= RESET_CAL_RESULT;
		end else if (step && active) begin
			in_pkt_q <= in_pkt_n;
			pos_q    <= pos + 15'd1;
			len_q    <= len_n;
			chan_q   <= chan_n;
			mact_q   <= mact_n;
			mfound_q <= mfound_n;
			moff_q   <= moff_n;
			lacc_q   <= lacc_n;
			lcal_q   <= lcal_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step && active) begin
			for (int i = 0; i < REPORT_BYTES; i++) begin
				rb_q[i] <= rb_n[i];
			end
			for (int i = 0; i < RESP_BYTES; i++) begin
				resp_q[i] <= resp_n[i];
			end
		end
	end

endmodule

### design/shtp_rpp_out_stage.sv
// ----------------------------------------------------------------------------
// shtp_rpp_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module shtp_rpp_out_stage
	import shtp_rpp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_valid,
	input  result_t res,
	output logic    advance,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    valid_q;
	result_t res_q;

	// The register frees up when empty or being drained this cycle.
	assign advance   = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

endmodule

### design/shtp_rotation_report_parser.sv
// ----------------------------------------------------------------------------
// shtp_rotation_report_parser
// Byte-serial SHTP packet decoder giving rotation reports and cal responses.
// ----------------------------------------------------------------------------
//
//  channel   dir  transaction                 contents
//  s_*       in   one packet byte             tdata: data_byte; tuser: packet_start
//  m_*       out  one result per packet       tuser: result_kind; tdata: see port
//  cfg_*     in   one register write          report_id, input_channel, control_channel
//
// Cycles: one byte a cycle sustained while m_tready drains the result register;
// the last byte of a packet is held in the input register while its decode
// settles into the result register, which then presents the result.
// The decode is combinational between the two registers, beside the packet state.
// Reset: arst_n clears all control state; config returns to 5 / 3 / 2 and
// the stored calibration result to 255.
// Stalls: a held result blocks the decoder; the input register still
// takes one byte while the result waits.
//
`include "shtp_rotation_report_parser_defines.svh"

module shtp_rotation_report_parser
	import shtp_rpp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] data_byte
	input  logic [0:0]           s_tuser,   // [0] packet_start
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [7:0] packet_channel, [22:8] scanned_length, [24:23] cal_accuracy,
	// [40:25] quat_i, [56:41] quat_j, [72:57] quat_k, [88:73] quat_real,
	// [104:89] heading_error_raw, [112:105] calibration_result, rest zero
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [1:0]           m_tuser,   // [1:0] result_kind
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_wdata
);

	item_t   in_item, item_s1;
	logic    valid_s1, advance, step, res_valid;
	result_t res, out_res;
	cfg_wr_t cfg;

	assign in_item.data_byte    = s_tdata;
	assign in_item.packet_start = s_tuser[0];
	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.wdata = cfg_wdata;

	// Advance the held byte only when the result register can take its result.
	assign step = valid_s1 && advance;

	shtp_rpp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	shtp_rpp_decoder u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	shtp_rpp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// Pack the result fields, lowest field first, pad to whole bytes.
	assign m_tuser = out_res.result_kind;
	assign m_tdata = {7'd0,
		out_res.calibration_result,
		out_res.heading_error_raw,
		out_res.quat_real,
		out_res.quat_k,
		out_res.quat_j,
		out_res.quat_i,
		out_res.cal_accuracy,
		out_res.scanned_length,
		out_res.packet_channel};

	// Hold the input side while a byte waits behind a blocked result.
	`SHTP_RPP_ASSERT_IMP(a_hold_input, (valid_s1 && m_tvalid && !m_tready), (!s_tready))
	// An invalid header reports no scanned payload.
	`SHTP_RPP_ASSERT_IMP(a_invalid_len, (m_tvalid && m_tuser == KIND_INVALID), (m_tdata[22:8] == 15'd0))
	// The scanned length never passes the scan window.
	`SHTP_RPP_ASSERT_IMP(a_scan_cap, (m_tvalid), (m_tdata[22:8] <= MAX_PAYLOAD))
	// A drained result with nothing new behind it leaves the output empty.
	`SHTP_RPP_ASSERT_NEXT(a_drain, (m_tvalid && m_tready && !res_valid), (!m_tvalid))

endmodule
